// ----- sv/fpw_pkg.sv -----
// Package with shared types, codes and helpers for the four-level page walker.
package fpw_pkg;

	localparam int unsigned VA_W      = 48;
	localparam int unsigned PA_W      = 64;
	localparam int unsigned IDX_W     = 9;
	localparam int unsigned OFF4K_W   = 12;
	localparam int unsigned OFF2M_W   = 21;
	localparam int unsigned ADDEND_W  = OFF2M_W;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic       ACT_TRANSLATE = 1'b0;
	localparam logic       ACT_RESPONSE  = 1'b1;
	localparam int unsigned PRESENT_BIT  = 0;
	localparam int unsigned LARGE_BIT    = 7;

	localparam logic [1:0] LVL_TOP = 2'd0;
	localparam logic [1:0] LVL_DIR = 2'd2;
	localparam logic [1:0] LVL_PT  = 2'd3;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  mapped;
		logic [PA_W-1:0]       base;
		logic [ADDEND_W-1:0]   addend;
	} op_t;

	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	function automatic logic [ADDEND_W-1:0] entry_offset(input logic [IDX_W-1:0] idx);
		return ADDEND_W'({idx, 3'b000});
	endfunction

endpackage

// ----- sv/fpw_ifs.sv -----
// Request and result channel interfaces of the page walker.
interface fpw_req_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [fpw_pkg::VA_W-1:0]   vaddr;
	logic [fpw_pkg::PA_W-1:0]   entry_data;

	modport source (output valid, action, vaddr, entry_data, input ready);
	modport sink   (input valid, action, vaddr, entry_data, output ready);
endinterface

interface fpw_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [fpw_pkg::PA_W-1:0]   read_address;
	logic [fpw_pkg::PA_W-1:0]   paddr;
	logic                       mapped;

	modport source (output valid, kind, read_address, paddr, mapped, input ready);
	modport sink   (input valid, kind, read_address, paddr, mapped, output ready);
endinterface

// ----- sv/fpw_front.sv -----
// Front end: accepts requests, tracks the walk state and classifies each request.
module fpw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fpw_pkg::PA_W-1:0]  cfg_wdata,
	fpw_req_if.sink                   req,
	input  logic                      q_full,
	output logic                      q_push,
	output fpw_pkg::op_t              q_op
);

	logic [fpw_pkg::PA_W-1:0]   root_base_q;
	logic                       busy_q;
	logic [1:0]                 level_q;
	logic [fpw_pkg::VA_W-1:0]   virt_q;
	logic                       busy_d;
	logic [1:0]                 level_d;
	logic [1:0]                 level_nx;
	logic                       present;
	logic [fpw_pkg::PA_W-1:0]   base_4k;
	logic [fpw_pkg::PA_W-1:0]   base_2m;

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;
	assign present   = req.entry_data[fpw_pkg::PRESENT_BIT];
	assign base_4k   = {req.entry_data[fpw_pkg::PA_W-1:fpw_pkg::OFF4K_W],
		{fpw_pkg::OFF4K_W{1'b0}}};
	assign base_2m   = {req.entry_data[fpw_pkg::PA_W-1:fpw_pkg::OFF2M_W],
		{fpw_pkg::OFF2M_W{1'b0}}};
	assign level_nx  = level_q + 2'd1;

	always_comb begin
		busy_d        = busy_q;
		level_d       = level_q;
		q_op.kind     = fpw_pkg::KIND_REJECT;
		q_op.mapped   = 1'b0;
		q_op.base     = '0;
		q_op.addend   = '0;
		if (req.action == fpw_pkg::ACT_TRANSLATE) begin
			if (!busy_q) begin
				busy_d      = 1'b1;
				level_d     = fpw_pkg::LVL_TOP;
				q_op.kind   = fpw_pkg::KIND_READ;
				q_op.base   = root_base_q;
				q_op.addend = fpw_pkg::entry_offset(
					fpw_pkg::level_index(req.vaddr, fpw_pkg::LVL_TOP));
			end
		end else if (busy_q) begin
			if (!present) begin
				busy_d    = 1'b0;
				level_d   = fpw_pkg::LVL_TOP;
				q_op.kind = fpw_pkg::KIND_DONE;
			end else if (level_q == fpw_pkg::LVL_DIR && req.entry_data[fpw_pkg::LARGE_BIT]) begin
				busy_d      = 1'b0;
				level_d     = fpw_pkg::LVL_TOP;
				q_op.kind   = fpw_pkg::KIND_DONE;
				q_op.mapped = 1'b1;
				q_op.base   = base_2m;
				q_op.addend = virt_q[fpw_pkg::OFF2M_W-1:0];
			end else if (level_q == fpw_pkg::LVL_PT) begin
				busy_d      = 1'b0;
				level_d     = fpw_pkg::LVL_TOP;
				q_op.kind   = fpw_pkg::KIND_DONE;
				q_op.mapped = 1'b1;
				q_op.base   = base_4k;
				q_op.addend = fpw_pkg::ADDEND_W'(virt_q[fpw_pkg::OFF4K_W-1:0]);
			end else begin
				level_d     = level_nx;
				q_op.kind   = fpw_pkg::KIND_READ;
				q_op.base   = base_4k;
				q_op.addend = fpw_pkg::entry_offset(fpw_pkg::level_index(virt_q, level_nx));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_base_q <= '0;
			busy_q      <= 1'b0;
			level_q     <= fpw_pkg::LVL_TOP;
			virt_q      <= '0;
		end else begin
			if (cfg_we) begin
				root_base_q <= cfg_wdata;
			end
			if (q_push) begin
				busy_q  <= busy_d;
				level_q <= level_d;
				if (req.action == fpw_pkg::ACT_TRANSLATE && !busy_q) begin
					virt_q <= req.vaddr;
				end
			end
		end
	end

endmodule

// ----- sv/fpw_queue.sv -----
// Short queue of classified operations between the front and back ends.
module fpw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fpw_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output fpw_pkg::op_t  pop_op
);

	fpw_pkg::op_t                 mem_q [fpw_pkg::QUEUE_DEPTH];
	logic [fpw_pkg::QPTR_W-1:0]   wr_q;
	logic [fpw_pkg::QPTR_W-1:0]   rd_q;
	logic [fpw_pkg::QCNT_W-1:0]   cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full      = cnt_q == fpw_pkg::QCNT_W'(fpw_pkg::QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_op    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == fpw_pkg::QPTR_W'(fpw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == fpw_pkg::QPTR_W'(fpw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/fpw_back.sv -----
// Back end: forms the read or final address and holds the result in the output register.
module fpw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  fpw_pkg::op_t  q_op,
	output logic          q_pop,
	fpw_rsp_if.source     rsp
);

	logic                       valid_q;
	logic [1:0]                 kind_q;
	logic [fpw_pkg::PA_W-1:0]   read_addr_q;
	logic [fpw_pkg::PA_W-1:0]   phys_q;
	logic                       mapped_q;
	logic [fpw_pkg::PA_W-1:0]   sum;

	assign q_pop = q_not_empty && (!valid_q || rsp.ready);
	assign sum   = q_op.base + fpw_pkg::PA_W'(q_op.addend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q      <= q_op.kind;
			mapped_q    <= q_op.mapped;
			read_addr_q <= (q_op.kind == fpw_pkg::KIND_READ) ? sum : '0;
			phys_q      <= (q_op.kind == fpw_pkg::KIND_DONE) ? sum : '0;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.kind         = kind_q;
	assign rsp.read_address = read_addr_q;
	assign rsp.paddr        = phys_q;
	assign rsp.mapped       = mapped_q;

endmodule

// ----- sv/four_level_page_walk.sv -----
// Top level of the four-level page-table walker.
//
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   action, vaddr, entry_data
// rsp       out        valid/ready   kind, read_address, paddr, mapped
// cfg       in         cfg_we        cfg_wdata (root table base)
//
// One request is taken per cycle while the queue is not full. Its queue entry is written when
// it is accepted; the back output register loads it once empty or while rsp.ready is high.
// While rsp is stalled the output register and the two-entry queue hold three results,
// after which req.ready drops.
// Reset clears the walk state, the root base, the queue and the output valid.
module four_level_page_walk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fpw_pkg::PA_W-1:0]  cfg_wdata,
	fpw_req_if.sink                   req,
	fpw_rsp_if.source                 rsp
);

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_not_empty;
	fpw_pkg::op_t  push_op;
	fpw_pkg::op_t  pop_op;

	fpw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op)
	);

	fpw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_op    (pop_op)
	);

	fpw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_op        (pop_op),
		.q_pop       (q_pop),
		.rsp         (rsp)
	);

endmodule
